// ===== hw/rtl/dtt_pkg.sv =====
// Shared constants, codes and transfer types of the deadline timer table.
package dtt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  localparam logic [31:0] WINDOW_RESET = 32'd3600000;

  localparam logic [2:0] K_ADD     = 3'd0;
  localparam logic [2:0] K_CANCEL  = 3'd1;
  localparam logic [2:0] K_REFRESH = 3'd2;
  localparam logic [2:0] K_RESET   = 3'd3;
  localparam logic [2:0] K_TICK    = 3'd4;
  localparam logic [2:0] K_QUERY   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [NUM_TIMERS-1:0] mask_t;
  typedef logic [3:0]            slot_t;

  typedef struct packed {
    logic [2:0]  kind;
    slot_t       slot;
    logic [31:0] period_ms;
    logic        recurring;
    logic        start_now;
    logic [63:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    slot_t       result_slot;
    logic [63:0] wait_ms;
    logic        front_notify;
    logic        any_active;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] period;
    logic [63:0] deadline;
  } entry_t;

endpackage

// ===== hw/rtl/dtt_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/deadline_timer_table_top.sv =====
// Top level of the deadline timer table: control sequencer around the slot memory.
//
// Periods and deadlines live in one RAM read one slot per cycle; active and
// recurring marks are flip-flops. Cancel, unknown kinds, items rejected at
// accept and a tick with no active slot finish in the accept cycle; refresh
// reads and rewrites its slot in S_RD; add, query and a tick with nothing due
// take one sweep of all slots; reset reads its slot in S_RD and sweeps if it
// re-arms the slot. A tick with expired slots takes one sweep per expired
// slot, plus a final re-arm sweep. A stalled result holds off the next
// transfer. No clearing pass follows reset. Each result is held in an output
// register until its transfer.
module deadline_timer_table_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dtt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dtt_pkg::out_item_t out_data_o
);
  import dtt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  localparam logic [1:0] M_EARLY = 2'd0;
  localparam logic [1:0] M_QUERY = 2'd1;
  localparam logic [1:0] M_TICK  = 2'd2;

  localparam idx_t LAST_IDX = idx_t'(NUM_TIMERS - 1);

  logic [2:0]  state_q, state_d;
  logic [1:0]  mode_q, mode_d;
  mask_t       active_q, active_d, rec_q, rec_d;
  logic        front_pending_q, front_pending_d;
  logic [63:0] last_seen_q, last_seen_d;
  logic [31:0] window_q, window_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        rv_q, rv_d;

  in_item_t    item_q, item_d;
  mask_t       hit_q, hit_d, rem_q, rem_d;
  logic        roll_q, roll_d;
  idx_t        ridx_q, ridx_d;
  logic        found_q, found_d;
  idx_t        best_q, best_d;
  logic [63:0] best_dl_q, best_dl_d;
  logic        early_q, early_d;
  logic [63:0] tgt_q, tgt_d;
  logic [31:0] wperiod_q, wperiod_d;
  idx_t        sidx_q, sidx_d;
  logic        pass0_q, pass0_d;

  logic        we;
  idx_t        waddr, raddr;
  entry_t      wdata, rdata;

  logic        in_fire, out_free, in_ok, free_found, cand, f_flag;
  idx_t        in_idx, free_idx;
  mask_t       rem_next;
  logic        push, p_tick, p_front, p_last;
  logic [1:0]  p_status;
  slot_t       p_slot;
  logic [63:0] p_wait;

  dtt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_ok      = 32'(in_data_i.slot) < 32'(NUM_TIMERS);
  assign in_idx     = idx_t'(in_data_i.slot);
  assign rem_next   = rem_q & ~(mask_t'(1) << best_q);
  assign f_flag     = early_q && !front_pending_q;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = idx_t'(i);
      end
    end
  end

  always_comb begin
    state_d         = state_q;
    mode_d          = mode_q;
    active_d        = active_q;
    rec_d           = rec_q;
    front_pending_d = front_pending_q;
    last_seen_d     = last_seen_q;
    window_d        = cfg_we_i ? cfg_wdata_i : window_q;
    cnt_d           = cnt_q;
    rv_d            = 1'b0;
    item_d          = item_q;
    hit_d           = hit_q;
    rem_d           = rem_q;
    roll_d          = roll_q;
    ridx_d          = ridx_q;
    found_d         = found_q;
    best_d          = best_q;
    best_dl_d       = best_dl_q;
    early_d         = early_q;
    tgt_d           = tgt_q;
    wperiod_d       = wperiod_q;
    sidx_d          = sidx_q;
    pass0_d         = pass0_q;
    we              = 1'b0;
    waddr           = sidx_q;
    wdata           = '{period: wperiod_q, deadline: tgt_q};
    raddr           = in_idx;
    cand            = 1'b0;
    push            = 1'b0;
    p_tick          = 1'b0;
    p_status        = ST_OK;
    p_slot          = '0;
    p_wait          = '0;
    p_front         = 1'b0;
    p_last          = 1'b1;

    if ((state_q == S_SCAN) || (state_q == S_UPD)) begin
      if (cnt_q < CNT_W'(NUM_TIMERS)) begin
        raddr  = cnt_q[IDX_W-1:0];
        rv_d   = 1'b1;
        ridx_d = cnt_q[IDX_W-1:0];
        cnt_d  = cnt_q + CNT_W'(1);
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          item_d = in_data_i;
          sidx_d = in_idx;
          cnt_d  = '0;
          case (in_data_i.kind)
            K_ADD: begin
              if (!free_found) begin
                push     = 1'b1;
                p_status = ST_FULL;
              end else begin
                sidx_d    = free_idx;
                tgt_d     = in_data_i.now_ms + 64'(in_data_i.period_ms);
                wperiod_d = in_data_i.period_ms;
                early_d   = 1'b1;
                mode_d    = M_EARLY;
                state_d   = S_SCAN;
              end
            end
            K_CANCEL: begin
              push = 1'b1;
              if (!in_ok || !active_q[in_idx]) begin
                p_status = ST_INACTIVE;
              end else begin
                active_d[in_idx] = 1'b0;
              end
            end
            K_REFRESH: begin
              if (!in_ok || !active_q[in_idx]) begin
                push     = 1'b1;
                p_status = ST_INACTIVE;
              end else begin
                state_d = S_RD;
              end
            end
            K_RESET: begin
              if (!in_ok) begin
                push     = 1'b1;
                p_status = ST_INACTIVE;
              end else begin
                state_d = S_RD;
              end
            end
            K_TICK: begin
              if (active_q != '0) begin
                roll_d      = (in_data_i.now_ms < last_seen_q) &&
                              ((last_seen_q - in_data_i.now_ms) > 64'(window_q));
                last_seen_d = in_data_i.now_ms;
                mode_d      = M_TICK;
                pass0_d     = 1'b1;
                hit_d       = '0;
                rem_d       = '0;
                found_d     = 1'b0;
                state_d     = S_SCAN;
              end
            end
            K_QUERY: begin
              front_pending_d = 1'b0;
              mode_d          = M_QUERY;
              found_d         = 1'b0;
              state_d         = S_SCAN;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        if (item_q.kind == K_REFRESH) begin
          we      = 1'b1;
          wdata   = '{period: rdata.period,
                      deadline: item_q.now_ms + 64'(rdata.period)};
          push    = 1'b1;
          state_d = S_IDLE;
        end else if ((rdata.period == item_q.period_ms) && !item_q.start_now) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end else if (!active_q[sidx_q]) begin
          push     = 1'b1;
          p_status = ST_INACTIVE;
          state_d  = S_IDLE;
        end else begin
          tgt_d     = (item_q.start_now ? item_q.now_ms
                                        : rdata.deadline - 64'(rdata.period))
                      + 64'(item_q.period_ms);
          wperiod_d = item_q.period_ms;
          early_d   = 1'b1;
          mode_d    = M_EARLY;
          cnt_d     = '0;
          state_d   = S_SCAN;
        end
      end

      S_SCAN: begin
        if (rv_q) begin
          case (mode_q)
            M_EARLY: begin
              if ((ridx_q != sidx_q) && active_q[ridx_q] &&
                  ((rdata.deadline < tgt_q) ||
                   ((rdata.deadline == tgt_q) && (ridx_q < sidx_q)))) begin
                early_d = 1'b0;
              end
            end
            M_QUERY, M_TICK: begin
              if (mode_q == M_QUERY) begin
                cand = active_q[ridx_q];
              end else if (pass0_q) begin
                cand = active_q[ridx_q] && (roll_q || (rdata.deadline <= item_q.now_ms));
                hit_d[ridx_q] = cand;
                rem_d[ridx_q] = cand;
              end else begin
                cand = rem_q[ridx_q];
              end
              if (cand && (!found_q || (rdata.deadline < best_dl_q))) begin
                found_d   = 1'b1;
                best_d    = ridx_q;
                best_dl_d = rdata.deadline;
              end
            end
            default: begin
            end
          endcase
          if (ridx_q == LAST_IDX) begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        case (mode_q)
          M_EARLY: begin
            if (f_flag) begin
              front_pending_d = 1'b1;
            end
            we    = 1'b1;
            waddr = sidx_q;
            if (item_q.kind == K_ADD) begin
              active_d[sidx_q] = 1'b1;
              rec_d[sidx_q]    = item_q.recurring;
              p_slot           = slot_t'(sidx_q);
            end
            push    = 1'b1;
            p_front = f_flag;
            state_d = S_IDLE;
          end
          M_QUERY: begin
            push = 1'b1;
            if (!found_q) begin
              p_wait = '1;
            end else if (item_q.now_ms >= best_dl_q) begin
              p_wait = '0;
            end else begin
              p_wait = best_dl_q - item_q.now_ms;
            end
            state_d = S_IDLE;
          end
          default: begin
            if (pass0_q && !found_q) begin
              state_d = S_IDLE;
            end else if (out_free) begin
              push    = 1'b1;
              p_tick  = 1'b1;
              p_slot  = slot_t'(best_q);
              p_last  = (rem_next == '0);
              rem_d   = rem_next;
              cnt_d   = '0;
              pass0_d = 1'b0;
              found_d = 1'b0;
              if (rem_next == '0) begin
                active_d = active_q & ~(hit_q & ~rec_q);
                state_d  = S_UPD;
              end else begin
                state_d = S_SCAN;
              end
            end
          end
        endcase
      end

      S_UPD: begin
        if (rv_q) begin
          if (hit_q[ridx_q] && rec_q[ridx_q]) begin
            we    = 1'b1;
            waddr = ridx_q;
            wdata = '{period: rdata.period,
                      deadline: item_q.now_ms + 64'(rdata.period)};
          end
          if (ridx_q == LAST_IDX) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = push || (out_valid_q && out_stall_i);
    out_d       = out_q;
    if (push) begin
      out_d = '{status:       p_status,
                result_slot:  p_slot,
                wait_ms:      p_wait,
                front_notify: p_front,
                any_active:   p_tick ? (|(active_q & ~(hit_q & ~rec_q)))
                                     : (|active_d),
                last:         p_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      mode_q          <= M_EARLY;
      active_q        <= '0;
      rec_q           <= '0;
      front_pending_q <= 1'b0;
      last_seen_q     <= '0;
      window_q        <= WINDOW_RESET;
      out_valid_q     <= 1'b0;
      cnt_q           <= '0;
      rv_q            <= 1'b0;
    end else begin
      state_q         <= state_d;
      mode_q          <= mode_d;
      active_q        <= active_d;
      rec_q           <= rec_d;
      front_pending_q <= front_pending_d;
      last_seen_q     <= last_seen_d;
      window_q        <= window_d;
      out_valid_q     <= out_valid_d;
      cnt_q           <= cnt_d;
      rv_q            <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    item_q    <= item_d;
    hit_q     <= hit_d;
    rem_q     <= rem_d;
    roll_q    <= roll_d;
    ridx_q    <= ridx_d;
    found_q   <= found_d;
    best_q    <= best_d;
    best_dl_q <= best_dl_d;
    early_q   <= early_d;
    tgt_q     <= tgt_d;
    wperiod_q <= wperiod_d;
    sidx_q    <= sidx_d;
    pass0_q   <= pass0_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input not stalled while busy");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ((state_q == S_RD) || (state_q == S_DONE) || (state_q == S_UPD)))
    else $error("slot RAM written outside a write state");

  a_read_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> ((state_q == S_SCAN) || (state_q == S_UPD)))
    else $error("read data tagged outside a sweep");

  a_no_push_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("held result overwritten");

endmodule
